// ----- rtl/tcce_pkg.sv -----
package tcce_pkg;

  // screen geometry in character cells
  localparam int COLUMNS = 30;
  localparam int ROWS    = 8;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  // result field widths
  localparam int KIND_W      = 3;
  localparam int F_COL_W     = 5;
  localparam int F_ROW_W     = 3;
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 8;

  // stream and register port widths
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = KIND_W;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 8;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TEXT_COLOR = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BACK_COLOR = 1'b1;

  // register reset values
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 8'd7;
  localparam logic [COLOR_W-1:0] BACK_COLOR_RST = 8'd0;

  // special key codes and drawn characters
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] KEY_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] KEY_ENTER     = 8'h0a;
  localparam logic [CHAR_W-1:0] KEY_CR        = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PROMPT   = 8'h3e;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ON   = 2'd1,
    OP_OFF  = 2'd2,
    OP_KEY  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GLYPH   = 3'd0,
    KIND_SCROLL  = 3'd1,
    KIND_BOX     = 3'd2,
    KIND_ERASE   = 3'd3,
    KIND_CMD_END = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    KEY_CLS_BS,
    KEY_CLS_ENTER,
    KEY_CLS_TAB,
    KEY_CLS_CR,
    KEY_CLS_OTHER
  } key_cls_t;

  typedef enum logic [1:0] {
    GLY_KEY,
    GLY_SPACE,
    GLY_PROMPT
  } glyph_sel_t;

  // cursor and blink state updates
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_TICK,
    ACT_ON,
    ACT_OFF,
    ACT_BACK,
    ACT_ADV,
    ACT_NEWLINE,
    ACT_COL1
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_GLYPH,
    ST_SCROLL,
    ST_MARKER,
    ST_PROMPT,
    ST_ERASE,
    ST_BOX
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       emit;
    kind_t      kind;
    logic       last;
    glyph_sel_t glyph_sel;
    act_t       act;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t      op;
    key_cls_t key_cls;
    logic     col_gt1;
    logic     col_at_end;
    logic     row_at_bottom;
    logic     adv_aligned;
    logic     enabled;
    logic     out_free;
  } dp_stat_t;

endpackage

// ----- rtl/tcce_ctrl.sv -----
module tcce_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tcce_pkg::dp_stat_t st,
  output tcce_pkg::ctl_cmd_t cmd
);
  import tcce_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   wrap_scroll;

  // an advance that wraps on the bottom row needs a scroll result
  assign wrap_scroll = st.col_at_end && st.row_at_bottom;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (st.op)
          OP_TICK, OP_ON: state_nxt = ST_BOX;
          OP_OFF:         state_nxt = ST_ERASE;
          OP_KEY: begin
            if (st.key_cls == KEY_CLS_CR) begin
              state_nxt = ST_BOX;
            end else if (st.key_cls == KEY_CLS_BS && !st.col_gt1) begin
              state_nxt = ST_BOX;
            end else begin
              state_nxt = ST_GLYPH;
            end
          end
        endcase
      end
      ST_GLYPH: begin
        if (st.out_free) begin
          unique case (st.key_cls)
            KEY_CLS_BS:    state_nxt = ST_BOX;
            KEY_CLS_ENTER: state_nxt = st.row_at_bottom ? ST_SCROLL : ST_MARKER;
            KEY_CLS_TAB: begin
              if (wrap_scroll)          state_nxt = ST_SCROLL;
              else if (st.adv_aligned)  state_nxt = ST_BOX;
              else                      state_nxt = ST_GLYPH;
            end
            default:       state_nxt = wrap_scroll ? ST_SCROLL : ST_BOX;
          endcase
        end
      end
      ST_SCROLL: begin
        if (st.out_free) begin
          state_nxt = (st.key_cls == KEY_CLS_ENTER) ? ST_MARKER : ST_BOX;
        end
      end
      ST_MARKER: begin
        if (st.out_free) state_nxt = ST_PROMPT;
      end
      ST_PROMPT: begin
        if (st.out_free) state_nxt = ST_BOX;
      end
      ST_ERASE: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      ST_BOX: begin
        if (!st.enabled || st.out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    in_tready     = 1'b0;
    cmd.latch     = 1'b0;
    cmd.emit      = 1'b0;
    cmd.kind      = KIND_GLYPH;
    cmd.last      = 1'b0;
    cmd.glyph_sel = GLY_SPACE;
    cmd.act       = ACT_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ST_DISPATCH: begin
        unique case (st.op)
          OP_TICK: cmd.act = ACT_TICK;
          OP_ON:   cmd.act = ACT_ON;
          OP_OFF:  cmd.act = ACT_OFF;
          OP_KEY:  cmd.act = ACT_NONE;
        endcase
      end
      ST_GLYPH: begin
        cmd.emit = st.out_free;
        cmd.kind = KIND_GLYPH;
        unique case (st.key_cls)
          KEY_CLS_BS: begin
            cmd.glyph_sel = GLY_SPACE;
            cmd.last      = !st.enabled;
            cmd.act       = st.out_free ? ACT_BACK : ACT_NONE;
          end
          KEY_CLS_ENTER: begin
            cmd.glyph_sel = GLY_SPACE;
            cmd.act       = st.out_free ? ACT_NEWLINE : ACT_NONE;
          end
          KEY_CLS_TAB: begin
            cmd.glyph_sel = GLY_SPACE;
            cmd.last      = !wrap_scroll && st.adv_aligned && !st.enabled;
            cmd.act       = st.out_free ? ACT_ADV : ACT_NONE;
          end
          default: begin
            cmd.glyph_sel = GLY_KEY;
            cmd.last      = !wrap_scroll && !st.enabled;
            cmd.act       = st.out_free ? ACT_ADV : ACT_NONE;
          end
        endcase
      end
      ST_SCROLL: begin
        cmd.emit = st.out_free;
        cmd.kind = KIND_SCROLL;
        cmd.last = (st.key_cls != KEY_CLS_ENTER) && !st.enabled;
      end
      ST_MARKER: begin
        cmd.emit = st.out_free;
        cmd.kind = KIND_CMD_END;
      end
      ST_PROMPT: begin
        cmd.emit      = st.out_free;
        cmd.kind      = KIND_GLYPH;
        cmd.glyph_sel = GLY_PROMPT;
        cmd.last      = !st.enabled;
        cmd.act       = st.out_free ? ACT_COL1 : ACT_NONE;
      end
      ST_ERASE: begin
        cmd.emit = st.out_free;
        cmd.kind = KIND_ERASE;
        cmd.last = 1'b1;
      end
      ST_BOX: begin
        cmd.emit = st.enabled && st.out_free;
        cmd.kind = KIND_BOX;
        cmd.last = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("result loaded while output register still full");

  // with the cursor hidden the sequence passes through a silent box state
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == ST_IDLE || (state_r == ST_BOX && !st.enabled)))
    else $error("sequence continued after its last result");

  a_erase_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ERASE && cmd.emit) |-> !st.enabled)
    else $error("erase emitted while cursor still enabled");

  a_accept_to_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> (state_r == ST_DISPATCH))
    else $error("accepted item not dispatched");
`endif

endmodule

// ----- rtl/tcce_dp.sv -----
module tcce_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [tcce_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [tcce_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tcce_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [tcce_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [tcce_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  tcce_pkg::ctl_cmd_t                   cmd,
  output tcce_pkg::dp_stat_t                   st
);
  import tcce_pkg::*;

  // latched item
  op_t               op_r;
  logic [CHAR_W-1:0] key_r;

  // cursor and blink state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             en_r, en_nxt;
  logic             lit_r, lit_nxt;
  logic             phase_r, phase_nxt;

  // color registers
  logic [COLOR_W-1:0] text_color_r, back_color_r;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_TUSER_W-1:0] out_user_r;
  logic                   out_last_r;

  logic [COL_W-1:0]   col_inc;
  logic               col_at_end, row_at_bottom;
  key_cls_t           key_cls;
  logic [F_COL_W-1:0] f_col;
  logic [F_ROW_W-1:0] f_row;
  logic [CHAR_W-1:0]  f_glyph;
  logic [COLOR_W-1:0] f_color;

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= op_t'(in_tuser);
      key_r <= in_tdata;
    end
  end

  // key classification
  always_comb begin
    unique case (key_r)
      KEY_BACKSPACE: key_cls = KEY_CLS_BS;
      KEY_ENTER:     key_cls = KEY_CLS_ENTER;
      KEY_TAB:       key_cls = KEY_CLS_TAB;
      KEY_CR:        key_cls = KEY_CLS_CR;
      default:       key_cls = KEY_CLS_OTHER;
    endcase
  end

  // cursor position flags
  assign col_inc       = col_r + COL_W'(1);
  assign col_at_end    = (col_r == COL_W'(COLUMNS - 1));
  assign row_at_bottom = (row_r == ROW_W'(ROWS - 1));

  // status to controller
  always_comb begin
    st.op            = op_r;
    st.key_cls       = key_cls;
    st.col_gt1       = (col_r > COL_W'(1));
    st.col_at_end    = col_at_end;
    st.row_at_bottom = row_at_bottom;
    st.adv_aligned   = col_at_end || (col_inc[1:0] == 2'b00);
    st.enabled       = en_r;
    st.out_free      = !out_valid_r || out_tready;
  end

  // cursor and blink updates
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    en_nxt    = en_r;
    lit_nxt   = lit_r;
    phase_nxt = phase_r;
    unique case (cmd.act)
      ACT_NONE: ;
      ACT_TICK: begin
        if (en_r) lit_nxt = phase_r;
        phase_nxt = !phase_r;
      end
      ACT_ON: begin
        en_nxt  = 1'b1;
        lit_nxt = 1'b1;
      end
      ACT_OFF:  en_nxt = 1'b0;
      ACT_BACK: col_nxt = col_r - COL_W'(1);
      ACT_ADV: begin
        if (col_at_end) begin
          col_nxt = '0;
          if (!row_at_bottom) row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_inc;
        end
      end
      ACT_NEWLINE: begin
        col_nxt = '0;
        if (!row_at_bottom) row_nxt = row_r + ROW_W'(1);
      end
      ACT_COL1: col_nxt = COL_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= COL_W'(1);
      row_r   <= '0;
      en_r    <= 1'b0;
      lit_r   <= 1'b0;
      phase_r <= 1'b1;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      en_r    <= en_nxt;
      lit_r   <= lit_nxt;
      phase_r <= phase_nxt;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= TEXT_COLOR_RST;
      back_color_r <= BACK_COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TEXT_COLOR: text_color_r <= cfg_wdata;
        CFG_BACK_COLOR: back_color_r <= cfg_wdata;
      endcase
    end
  end

  // result fields
  always_comb begin
    f_col   = '0;
    f_row   = '0;
    f_glyph = '0;
    f_color = '0;
    case (cmd.kind)
      KIND_GLYPH: begin
        f_col   = F_COL_W'(col_r);
        f_row   = F_ROW_W'(row_r);
        f_color = text_color_r;
        case (cmd.glyph_sel)
          GLY_KEY:    f_glyph = key_r;
          GLY_PROMPT: f_glyph = CHAR_PROMPT;
          default:    f_glyph = CHAR_SPACE;
        endcase
      end
      KIND_BOX: begin
        f_col   = F_COL_W'(col_r);
        f_row   = F_ROW_W'(row_r);
        f_color = lit_r ? text_color_r : back_color_r;
      end
      KIND_ERASE: begin
        f_col   = F_COL_W'(col_r);
        f_row   = F_ROW_W'(row_r);
        f_color = back_color_r;
      end
      default: ;
    endcase
    out_data_nxt = {f_color, f_glyph, f_row, f_col};
  end

  // output register
  always_comb begin
    if (cmd.emit)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= out_data_nxt;
      out_user_r <= cmd.kind;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(COLUMNS - 1))
    else $error("cursor column beyond last column");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(ROWS - 1))
    else $error("cursor row beyond last row");

  a_box_only_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.kind == KIND_BOX) |-> en_r)
    else $error("cursor box drawn while cursor hidden");
`endif

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// Text console cursor engine: takes one console event per input item (blink
// tick, cursor on, cursor off, keystroke) and emits the resulting glyph
// writes, scroll-ups, end-of-command markers and cursor box draws, one result
// per cycle unless the output stalls, with tlast on each event's last result.
// Events are handled one at a time by a small sequencer: an item is latched
// in idle and decoded in dispatch, then each result has its own state, and a
// hidden cursor ends the event in a silent box state unless an erase does.
// The single output register decouples the sides; a stalled result holds the
// sequencer and so the input. Color registers are written through cfg_we /
// cfg_addr / cfg_wdata (0 text color, 1 back color); users write them only
// while no event is pending; the block itself does not enforce it.
module text_console_cursor_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: key_code[7:0]
  input  logic [tcce_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: op[1:0]
  input  logic [tcce_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: column[4:0], row[7:5], glyph[15:8], color[23:16]
  output logic [tcce_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: kind[2:0]
  output logic [tcce_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [tcce_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tcce_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;

  // event sequencer
  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // cursor state, colors and output register
  tcce_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
